>>> hdl/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// Shared types, fixed-point constants and multiply helpers of the easing
// curve evaluator. Internal arithmetic is Q28 (1.0 = 2^28).
// ----------------------------------------------------------------------------
package ece_pkg;

	localparam int FX = 28;        // internal fraction bits
	localparam int XW = FX + 1;    // unsigned value in [0, 1]
	localparam int AW = 32;        // signed accumulator width
	localparam int VW = XW + 5;    // signed curve value width
	localparam int NW = 4;         // exponent shift width

	localparam longint ONE_L = 64'sd1 <<< FX;
	localparam logic [XW-1:0] ONE_X = {1'b1, {FX{1'b0}}};

	typedef enum logic [3:0] {
		MODE_LINEAR  = 4'd0,
		MODE_QUAD    = 4'd1,
		MODE_CUBIC   = 4'd2,
		MODE_QUART   = 4'd3,
		MODE_QUINT   = 4'd4,
		MODE_SINE    = 4'd5,
		MODE_EXPO    = 4'd6,
		MODE_CIRC    = 4'd7,
		MODE_BACK    = 4'd8,
		MODE_ELASTIC = 4'd9,
		MODE_BOUNCE  = 4'd10
	} ece_mode_t;

	// sin(pi/2 * r) as an odd polynomial in r, Horner form in r^2.
	localparam logic signed [AW-1:0] SIN_TOP = -32'sd966;
	localparam logic signed [AW-1:0] SIN_C [0:4] = '{
		32'sd43068, -32'sd1256747, 32'sd21392327, -32'sd173399667, 32'sd421657428
	};

	// 2^f for f in [0, 1), Horner form in f.
	localparam logic signed [AW-1:0] EXP_TOP = 32'sd4094;
	localparam logic signed [AW-1:0] EXP_C [0:6] = '{
		32'sd41349, 32'sd357920, 32'sd2581871, 32'sd14899271,
		32'sd64485312, 32'sd186065279, 32'sd268435456
	};

	localparam logic [XW:0] BACK_C1 = 30'd456764403;
	localparam logic [XW:0] BACK_C3 = 30'd725199859;

	// Bounce segments: limits on 11*t, parabola centers and offsets.
	localparam logic [31:0] B_LIM1 = 32'(4 * ONE_L);
	localparam logic [31:0] B_LIM2 = 32'(8 * ONE_L);
	localparam logic [31:0] B_LIM3 = 32'(10 * ONE_L);
	localparam logic [XW-1:0] B_CTR1 = XW'((6 * ONE_L + 5) / 11);
	localparam logic [XW-1:0] B_CTR2 = XW'((9 * ONE_L + 5) / 11);
	localparam logic [XW-1:0] B_CTR3 = XW'((21 * ONE_L + 11) / 22);
	localparam logic [XW-1:0] B_OFS1 = XW'(3 * ONE_L / 4);
	localparam logic [XW-1:0] B_OFS2 = XW'(15 * ONE_L / 16);
	localparam logic [XW-1:0] B_OFS3 = XW'(63 * ONE_L / 64);

	localparam logic [2*XW-1:0] RND_U = (2*XW)'(1) << (FX - 1);
	localparam logic signed [AW+XW:0] RND_S = (AW+XW+1)'(1) << (FX - 1);

	// Values that travel with an item down the pipeline.
	typedef struct packed {
		logic [3:0]             mode;
		logic                   inv;   // result is 1 - f(x)
		logic                   xz;    // x is zero
		logic [XW-1:0]          x;
		logic [XW-1:0]          x2;
		logic [XW-1:0]          r;     // reduced sine argument, quarter turns
		logic [XW-1:0]          rr;
		logic                   sneg;
		logic [FX-1:0]          f;     // fraction of the exponent
		logic [NW-1:0]          n;     // integer shift of the exponent
		logic signed [AW-1:0]   sn;
		logic [XW-1:0]          ex;
		logic signed [VW-1:0]   val;
	} ece_side_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} ece_sqrt_t;

	function automatic logic [XW-1:0] fmul_u(input logic [XW-1:0] a,
		input logic [XW-1:0] b);
		logic [2*XW-1:0] p;
		begin
			p = a * b;
			p = p + RND_U;
			return p[FX+XW-1:FX];
		end
	endfunction

	function automatic logic signed [AW-1:0] fmul_s(input logic signed [AW-1:0] a,
		input logic [XW-1:0] b);
		logic signed [AW+XW:0] p;
		begin
			p = a * $signed({1'b0, b});
			p = p + RND_S;
			return p[FX+AW-1:FX];
		end
	endfunction

endpackage

>>> hdl/ece_mac_stage.sv
// ----------------------------------------------------------------------------
// ece_mac_stage
// One registered Horner step: result = acc * mult + coef in Q28.
// ----------------------------------------------------------------------------
module ece_mac_stage (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ece_pkg::AW-1:0]       acc,
	input  logic [ece_pkg::XW-1:0]              mult,
	input  logic signed [ece_pkg::AW-1:0]       coef,
	output logic signed [ece_pkg::AW-1:0]       result
);

	always_ff @(posedge clk) begin
		if (en) begin
			result <= ece_pkg::fmul_s(acc, mult) + coef;
		end
	end

endmodule

>>> hdl/ece_sqrt_stage.sv
// ----------------------------------------------------------------------------
// ece_sqrt_stage
// Four digit-recurrence steps of an integer square root, then a register.
// ----------------------------------------------------------------------------
module ece_sqrt_stage (
	input  logic                clk,
	input  logic                en,
	input  ece_pkg::ece_sqrt_t  cur,
	output ece_pkg::ece_sqrt_t  nxt
);

	ece_pkg::ece_sqrt_t st;

	always_comb begin
		logic [33:0] rem2;
		logic [33:0] trial;
		st = cur;
		for (int i = 0; i < 4; i++) begin
			rem2  = {st.rem[31:0], st.rad[63:62]};
			trial = {st.root, 2'b01};
			if (rem2 >= trial) begin
				st.rem  = rem2 - trial;
				st.root = {st.root[30:0], 1'b1};
			end else begin
				st.rem  = rem2;
				st.root = {st.root[30:0], 1'b0};
			end
			st.rad = {st.rad[61:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxt <= st;
		end
	end

endmodule

>>> hdl/easing_curve_evaluator_top.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator_top
// Evaluates the Penner easing curves on a progress value in fixed point.
// ----------------------------------------------------------------------------
//  channel | signals                               | meaning
//  --------+---------------------------------------+---------------------------
//  input   | in_valid, in_ready, mode, direction,  | one curve request
//          | progress                              |
//  output  | out_valid, out_ready, eased_value     | eased value, signed Q2.F
//
// One request enters per cycle while the output is not stalled; the depth of
// the pipe is set by the sine and exponent Horner chains and the square root.
// A stall on the output freezes every stage at once, so nothing is lost.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_top #(
	parameter int FRAC_BITS = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0]                   mode,
	input  logic                         direction,
	input  logic [FRAC_BITS:0]           progress,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FRAC_BITS+1:0]  eased_value
);

	localparam int FX  = ece_pkg::FX;
	localparam int XW  = ece_pkg::XW;
	localparam int AW  = ece_pkg::AW;
	localparam int VW  = ece_pkg::VW;
	localparam int SH  = FX - FRAC_BITS;
	localparam int OW  = FRAC_BITS + 2;
	localparam int NST = 12;

	localparam logic [FRAC_BITS:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [VW-1:0] ONE_V = {{(VW-XW){1'b0}}, ece_pkg::ONE_X};
	localparam logic signed [VW-1:0] RND_O = VW'(1) << (SH - 1);
	localparam logic signed [VW-1:0] LIM_HI = VW'((64'sd1 <<< (FRAC_BITS + 1)) - 1);
	localparam logic signed [VW-1:0] LIM_LO = -LIM_HI - 1;

	logic en;
	logic [NST:1] v_s;
	ece_pkg::ece_side_t side_s [1:11];
	ece_pkg::ece_side_t side_d [1:11];

	logic signed [XW:0]    bd_s2;
	logic [XW-1:0]         bc_s2;
	logic signed [AW-1:0]  b1_s2;
	logic [XW-1:0]         x3_s3, x4_s3, dd_s3, bc_s3;
	logic signed [AW-1:0]  bk_s3;
	logic signed [OW-1:0]  res_s12;

	logic signed [XW:0]    bd_d;
	logic [XW-1:0]         bc_d;
	logic signed [AW-1:0]  b1_d;
	logic signed [OW-1:0]  res_d;
	logic [XW-1:0]         ad_abs;

	logic signed [AW-1:0]  sacc_in [4:8];
	logic signed [AW-1:0]  sacc    [4:8];
	logic signed [AW-1:0]  eacc_in [3:9];
	logic signed [AW-1:0]  eacc    [3:9];
	ece_pkg::ece_sqrt_t    sq_in   [3:10];
	ece_pkg::ece_sqrt_t    sq      [3:10];

	// The whole pipe moves unless a finished result is held at the output.
	assign en        = out_ready || !out_valid;
	assign in_ready  = en;
	assign out_valid = v_s[NST];
	assign eased_value = res_s12;

	always_comb begin
		logic [FRAC_BITS:0]  p_sat;
		logic [XW-1:0]       t;
		logic                flip;
		logic [31:0]         ph;
		logic [XW-1:0]       om;
		logic [31:0]         m;
		logic [31:0]         mc;
		logic [31:0]         fn;
		logic [31:0]         x11;
		logic [XW-1:0]       ctr;
		logic [2*XW:0]       bp;
		logic [XW+6:0]       bm;
		logic [XW-1:0]       bo;
		logic [AW-1:0]       eu;
		logic [AW-1:0]       exr;
		logic signed [VW-1:0] rv;
		logic signed [VW-1:0] rs;
		ece_pkg::ece_side_t  s;

		// Stage 1: saturate, mirror for the out direction.
		p_sat = (progress > ONE_P) ? ONE_P : progress;
		t     = {p_sat, {SH{1'b0}}};
		flip  = (mode == ece_pkg::MODE_BOUNCE) ? !direction : direction;
		s     = '0;
		s.mode = mode;
		s.inv  = (mode <= ece_pkg::MODE_ELASTIC) ? direction :
			((mode == ece_pkg::MODE_BOUNCE) ? !direction : 1'b0);
		s.x    = flip ? ece_pkg::ONE_X - t : t;
		side_d[1] = s;

		// Stage 2: square, sine phase, exponent split, bounce segment.
		s = side_s[1];
		s.x2 = ece_pkg::fmul_u(s.x, s.x);
		s.xz = (s.x == '0);
		if (s.mode == ece_pkg::MODE_SINE) begin
			ph = {3'b000, s.x} + {3'b000, ece_pkg::ONE_X};
		end else begin
			ph = ({3'b000, s.x} << 3) + ({3'b000, s.x} << 2) + {3'b000, s.x};
		end
		s.r    = ph[FX] ? ece_pkg::ONE_X - {1'b0, ph[FX-1:0]} : {1'b0, ph[FX-1:0]};
		s.sneg = ph[FX+1];
		om = ece_pkg::ONE_X - s.x;
		m  = ({3'b000, om} << 3) + ({3'b000, om} << 1);
		mc = m + 32'(ece_pkg::ONE_L - 1);
		s.n = mc[FX+ece_pkg::NW-1:FX];
		fn  = 32'({s.n, {FX{1'b0}}}) - m;
		s.f = fn[FX-1:0];
		side_d[2] = s;

		x11 = ({3'b000, side_s[1].x} << 3) + ({3'b000, side_s[1].x} << 1)
			+ {3'b000, side_s[1].x};
		if (x11 < ece_pkg::B_LIM1) begin
			ctr  = '0;
			bc_d = '0;
		end else if (x11 < ece_pkg::B_LIM2) begin
			ctr  = ece_pkg::B_CTR1;
			bc_d = ece_pkg::B_OFS1;
		end else if (x11 < ece_pkg::B_LIM3) begin
			ctr  = ece_pkg::B_CTR2;
			bc_d = ece_pkg::B_OFS2;
		end else begin
			ctr  = ece_pkg::B_CTR3;
			bc_d = ece_pkg::B_OFS3;
		end
		bd_d = $signed({1'b0, side_s[1].x}) - $signed({1'b0, ctr});
		bp   = ece_pkg::BACK_C3 * side_s[1].x;
		bp   = bp + (2*XW+1)'(ece_pkg::RND_U);
		b1_d = $signed({2'b00, bp[FX+XW:FX]}) - $signed({2'b00, ece_pkg::BACK_C1});

		// Stage 3: square of the sine argument.
		s = side_s[2];
		s.rr = ece_pkg::fmul_u(s.r, s.r);
		side_d[3] = s;

		// Stage 4: polynomial curves are final here.
		s  = side_s[3];
		bm = dd_s3 * 7'd121;
		bo = bm[XW+3:4] + bc_s3;
		case (ece_pkg::ece_mode_t'(s.mode))
			ece_pkg::MODE_LINEAR: s.val = {{(VW-XW){1'b0}}, s.x};
			ece_pkg::MODE_QUAD:   s.val = {{(VW-XW){1'b0}}, s.x2};
			ece_pkg::MODE_CUBIC:  s.val = {{(VW-XW){1'b0}}, x3_s3};
			ece_pkg::MODE_QUART:  s.val = {{(VW-XW){1'b0}}, x4_s3};
			ece_pkg::MODE_QUINT:
				s.val = {{(VW-XW){1'b0}}, ece_pkg::fmul_u(x4_s3, s.x)};
			ece_pkg::MODE_BACK:   s.val = VW'(bk_s3);
			ece_pkg::MODE_BOUNCE: s.val = {{(VW-XW){1'b0}}, bo};
			default:              s.val = '0;
		endcase
		side_d[4] = s;

		for (int k = 5; k <= 8; k++) begin
			side_d[k] = side_s[k-1];
		end

		// Stage 9: finish the sine.
		s = side_s[8];
		s.sn = ece_pkg::fmul_s(sacc[8], s.r);
		if (s.sneg) begin
			s.sn = -s.sn;
		end
		if (s.mode == ece_pkg::MODE_SINE) begin
			s.val = ONE_V - VW'(s.sn);
		end
		side_d[9] = s;

		// Stage 10: scale 2^f by 2^-n with rounding.
		s   = side_s[9];
		eu  = eacc[9];
		exr = (eu + ((AW'(1) << s.n) >> 1)) >> s.n;
		s.ex = exr[XW-1:0];
		if (s.mode == ece_pkg::MODE_EXPO) begin
			s.val = s.xz ? '0 : {{(VW-XW){1'b0}}, s.ex};
		end
		side_d[10] = s;

		// Stage 11: elastic product and circular root.
		s = side_s[10];
		if (s.mode == ece_pkg::MODE_ELASTIC) begin
			s.val = VW'(ece_pkg::fmul_s(s.sn, s.ex));
		end else if (s.mode == ece_pkg::MODE_CIRC) begin
			s.val = ONE_V - $signed({{(VW-32){1'b0}}, sq[10].root});
		end
		side_d[11] = s;

		// Output stage: mirror back, round to the output format, clamp.
		rv = side_s[11].inv ? ONE_V - side_s[11].val : side_s[11].val;
		rs = (rv + RND_O) >>> SH;
		if (rs > LIM_HI) begin
			rs = LIM_HI;
		end else if (rs < LIM_LO) begin
			rs = LIM_LO;
		end
		res_d = rs[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= 11; k++) begin
				side_s[k] <= side_d[k];
			end
			bd_s2 <= bd_d;
			bc_s2 <= bc_d;
			b1_s2 <= b1_d;
			x3_s3 <= ece_pkg::fmul_u(side_s[2].x2, side_s[2].x);
			x4_s3 <= ece_pkg::fmul_u(side_s[2].x2, side_s[2].x2);
			bk_s3 <= ece_pkg::fmul_s(b1_s2, side_s[2].x2);
			dd_s3 <= ece_pkg::fmul_u(ad_abs, ad_abs);
			bc_s3 <= bc_s2;
			res_s12 <= res_d;
		end
	end

	assign ad_abs = bd_s2[XW] ? XW'(-bd_s2) : XW'(bd_s2);

	// Sine chain: odd polynomial in the reduced argument.
	for (genvar k = 4; k <= 8; k++) begin : g_sin
		if (k == 4) begin : g_first
			assign sacc_in[k] = ece_pkg::SIN_TOP;
		end else begin : g_next
			assign sacc_in[k] = sacc[k-1];
		end
		ece_mac_stage u_mac (
			.clk    (clk),
			.en     (en),
			.acc    (sacc_in[k]),
			.mult   (side_s[k-1].rr),
			.coef   (ece_pkg::SIN_C[k-4]),
			.result (sacc[k])
		);
	end

	// Exponent chain: 2^f on the fraction of the exponent.
	for (genvar k = 3; k <= 9; k++) begin : g_exp
		if (k == 3) begin : g_first
			assign eacc_in[k] = ece_pkg::EXP_TOP;
		end else begin : g_next
			assign eacc_in[k] = eacc[k-1];
		end
		ece_mac_stage u_mac (
			.clk    (clk),
			.en     (en),
			.acc    (eacc_in[k]),
			.mult   ({1'b0, side_s[k-1].f}),
			.coef   (ece_pkg::EXP_C[k-3]),
			.result (eacc[k])
		);
	end

	// Square root of 1 - x^2, four result bits per stage.
	for (genvar k = 3; k <= 10; k++) begin : g_sqrt
		if (k == 3) begin : g_first
			assign sq_in[k] = '{
				rad:  {7'd0, ece_pkg::ONE_X - side_s[2].x2, {FX{1'b0}}},
				rem:  '0,
				root: '0
			};
		end else begin : g_next
			assign sq_in[k] = sq[k-1];
		end
		ece_sqrt_stage u_sqrt (
			.clk (clk),
			.en  (en),
			.cur (sq_in[k]),
			.nxt (sq[k])
		);
	end

endmodule

>>> hdl/ece_checker.sv
// ----------------------------------------------------------------------------
// ece_checker
// Port-level checks of the easing curve evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module ece_checker #(
	parameter int FRAC_BITS = 15
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [FRAC_BITS+1:0]  eased_value
);

	// A held result must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(eased_value))
		else $error("result changed while stalled");

	// The pipe takes a request whenever the output slot can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("input ready does not follow the output stall");

	// Once reset has been seen at an edge, no result is shown at the next one.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

	// A stalled output blocks new requests.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while the output is stalled");

endmodule

bind easing_curve_evaluator_top ece_checker #(.FRAC_BITS(FRAC_BITS)) u_ece_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.eased_value (eased_value)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives curve requests into the easing curve evaluator with bursty input
// traffic and a stalling receiver. A fixed-point predictor computes each
// eased value, and every result is checked in order within two LSB.
// ----------------------------------------------------------------------------
module tb;

	localparam int FB = 15;
	localparam int QF = 28;
	localparam longint Q1 = 64'sd1 <<< QF;
	localparam longint Q_HALF_PI = 64'sd421657428;
	localparam longint Q_PI = 64'sd843314857;
	localparam longint Q_TWO_PI = 64'sd1686629713;
	localparam longint Q_LN2 = 64'sd186065279;
	localparam longint Q_BACK1 = (Q1 * 170158 + 50000) / 100000;
	localparam longint Q_BACK3 = (Q1 * 270158 + 50000) / 100000;
	localparam int TOL = 2;
	localparam int N_RANDOM = 550;

	typedef struct packed {
		logic [3:0]  mode;
		logic        direction;
		logic [15:0] progress;
	} curve_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] mode = '0;
	logic direction = 1'b0;
	logic [FB:0] progress = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [FB+1:0] eased_value;

	curve_req_t pending_reqs[$];
	logic signed [FB+1:0] expected_values[$];
	bit stimulus_ready = 1'b0;
	bit req_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	int stall_len = 3;
	int errors = 0;

	easing_curve_evaluator_top #(.FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .direction(direction), .progress(progress),
		.out_valid(out_valid), .out_ready(out_ready),
		.eased_value(eased_value)
	);

	function automatic longint qmul(longint a, longint b);
		bit neg;
		longint unsigned ua, ub, p;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = (ua * ub + (64'd1 << (QF - 1))) >> QF;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint qsin(longint x);
		longint r, sum, term, x2;
		bit neg;
		r = x - (x / Q_TWO_PI) * Q_TWO_PI;
		neg = 1'b0;
		if (r >= Q_PI) begin
			r -= Q_PI;
			neg = 1'b1;
		end
		if (r > Q_HALF_PI) r = Q_PI - r;
		x2 = qmul(r, r);
		sum = r;
		term = r;
		for (int n = 1; n <= 8; n++) begin
			term = -qmul(term, x2) / longint'((2 * n) * (2 * n + 1));
			sum += term;
		end
		return neg ? -sum : sum;
	endfunction

	// 2^(-m) for m >= 0: integer shift times a series for the fraction.
	function automatic longint qexp2_neg(longint m);
		longint n, f, z, sum, term;
		n = (m + Q1 - 1) >>> QF;
		f = n * Q1 - m;
		z = qmul(f, Q_LN2);
		sum = Q1;
		term = Q1;
		for (int i = 1; i <= 12; i++) begin
			term = qmul(term, z) / i;
			sum += term;
		end
		if (n >= 40) return 0;
		if (n == 0) return sum;
		return longint'((longint'(unsigned'(sum)) + (64'd1 << (n - 1))) >> n);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint bounce_curve(longint t);
		longint d, c;
		if (11 * t < 4 * Q1) begin
			d = t; c = 0;
		end else if (11 * t < 8 * Q1) begin
			d = t - (6 * Q1 + 5) / 11; c = 3 * Q1 / 4;
		end else if (11 * t < 10 * Q1) begin
			d = t - (9 * Q1 + 5) / 11; c = 15 * Q1 / 16;
		end else begin
			d = t - (21 * Q1 + 11) / 22; c = 63 * Q1 / 64;
		end
		return qmul(d, d) * 121 / 16 + c;
	endfunction

	function automatic longint ease_in_curve(logic [3:0] m, longint t);
		longint t2;
		t2 = qmul(t, t);
		case (m)
			ece_pkg::MODE_LINEAR: return t;
			ece_pkg::MODE_QUAD:   return t2;
			ece_pkg::MODE_CUBIC:  return qmul(t2, t);
			ece_pkg::MODE_QUART:  return qmul(t2, t2);
			ece_pkg::MODE_QUINT:  return qmul(qmul(t2, t2), t);
			ece_pkg::MODE_SINE:   return Q1 - qsin(qmul(t, Q_HALF_PI) + Q_HALF_PI);
			ece_pkg::MODE_EXPO:   return (t == 0) ? 0 : qexp2_neg(10 * Q1 - 10 * t);
			ece_pkg::MODE_CIRC:
				return Q1 - longint'(int_sqrt(longint'(Q1 - t2) << QF));
			ece_pkg::MODE_BACK:   return qmul(t2, qmul(Q_BACK3, t) - Q_BACK1);
			default:              return qmul(qsin(13 * qmul(t, Q_HALF_PI)),
				qexp2_neg(10 * Q1 - 10 * t));
		endcase
	endfunction

	function automatic logic signed [FB+1:0] eased_prediction(curve_req_t rq);
		longint t, r, v;
		longint unsigned u, p;
		p = rq.progress;
		if (p > (64'd1 << FB)) p = 64'd1 << FB;
		t = longint'(p << (QF - FB));
		if (rq.mode > ece_pkg::MODE_BOUNCE) r = 0;
		else if (rq.mode == ece_pkg::MODE_BOUNCE)
			r = rq.direction ? bounce_curve(t) : Q1 - bounce_curve(Q1 - t);
		else
			r = rq.direction ? Q1 - ease_in_curve(rq.mode, Q1 - t)
				: ease_in_curve(rq.mode, t);
		u = r + 8 * Q1;
		u = (u + (64'd1 << (QF - FB - 1))) >> (QF - FB);
		v = longint'(u) - (64'sd8 <<< FB);
		if (v < -(64'sd1 <<< (FB + 1))) v = -(64'sd1 <<< (FB + 1));
		if (v > (64'sd1 <<< (FB + 1)) - 1) v = (64'sd1 <<< (FB + 1)) - 1;
		return v[FB+1:0];
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		curve_req_t rq;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Every selector, including unknown ones, at one of zero, one and saturation.
		for (int m = 0; m < 16; m++) begin
			rq.mode = 4'(m);
			rq.direction = m[0];
			rq.progress = (m % 3 == 0) ? 16'd0 : (m % 3 == 1) ? 16'd32768 : 16'hFFFF;
			pending_reqs.push_back(rq);
		end
		// Expo at its special points, both directions.
		for (int k = 0; k < 4; k++) begin
			rq.mode = ece_pkg::MODE_EXPO;
			rq.direction = k[0];
			rq.progress = k[1] ? 16'd32768 : 16'd0;
			pending_reqs.push_back(rq);
		end
		for (int k = 0; k < 4; k++) begin
			rq.mode = k[1] ? ece_pkg::MODE_ELASTIC : ece_pkg::MODE_BACK;
			rq.direction = k[0];
			rq.progress = 16'd16384;
			pending_reqs.push_back(rq);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			rq.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			rq.direction = 1'($urandom_range(0, 1));
			rq.progress = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 32768));
			pending_reqs.push_back(rq);
		end
		stimulus_ready = 1'b1;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		curve_req_t rq;
		if (arst_n && stimulus_ready && (!in_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				rq = pending_reqs.pop_front();
				mode <= rq.mode;
				direction <= rq.direction;
				progress <= rq.progress;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver: ready and stall stretches of random length, each picked at random.
	always @(negedge clk) begin
		if (stall_phase >= stall_len) begin
			stall_phase <= 0;
			stall_len <= $urandom_range(1, 25);
			out_ready <= ($urandom_range(0, 2) != 0);
		end else begin
			stall_phase <= stall_phase + 1;
		end
	end

	always @(posedge clk) begin
		curve_req_t rq;
		int diff;
		logic signed [FB+1:0] want;
		req_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			rq.mode = mode;
			rq.direction = direction;
			rq.progress = progress;
			expected_values.push_back(eased_prediction(rq));
		end
		if (out_valid && out_ready) begin
			if (expected_values.size() == 0) begin
				$error("unexpected result eased_value=%0d", eased_value);
				errors++;
			end else begin
				want = expected_values.pop_front();
				diff = int'(eased_value) - int'(want);
				if (diff > TOL || diff < -TOL) begin
					$error("eased_value expected %0d actual %0d", want, eased_value);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stimulus_ready);
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_values.size() == 0);
		repeat (40) @(posedge clk);
		if (expected_values.size() != 0) errors++;
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ece_pkg.sv
hdl/ece_mac_stage.sv
hdl/ece_sqrt_stage.sv
hdl/easing_curve_evaluator_top.sv
hdl/ece_checker.sv
test/tb.sv
